// ===== design/ptt_pkg.sv =====
// Package for the periodic task timer table.
// Holds operation and result codes, the table entry type and the divide-by-ten constants.
// No dependencies.
package ptt_pkg;

    localparam logic [1:0] OP_ADD      = 2'd0;
    localparam logic [1:0] OP_TICK     = 2'd1;
    localparam logic [1:0] OP_DISPATCH = 2'd2;

    localparam logic [1:0] KIND_ADDED    = 2'd0;
    localparam logic [1:0] KIND_REJECTED = 2'd1;
    localparam logic [1:0] KIND_RUN      = 2'd2;
    localparam logic [1:0] KIND_NONE     = 2'd3;

    // x / 10 == (x * 52429) >> 19 for every 16-bit x
    localparam logic [15:0] RECIP10     = 16'd52429;
    localparam int          DIV10_SHIFT = 19;
    localparam logic [7:0]  PENDING_MAX = 8'hFF;

    typedef struct packed {
        logic [15:0] handle;
        logic [15:0] ticks;
        logic [15:0] period;
        logic [7:0]  pending;
    } entry_t;

endpackage

// ===== design/ptt_mem.sv =====
// Slot table memory: one write port, one read port, registered read data.
// Depends on ptt_pkg for the entry type.
module ptt_mem
    import ptt_pkg::*;
#(
    parameter int DEPTH  = 8,
    parameter int ADDR_W = 3
)
(
    input  logic              clk,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output entry_t            rd_data,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  entry_t            wr_data
);

    entry_t mem [DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/ptt_conv.sv =====
// Millisecond to tick conversion, (ms / 10) + 1, with a registered product.
// Depends on ptt_pkg for the reciprocal constants.
module ptt_conv
    import ptt_pkg::*;
(
    input  logic        clk,
    input  logic [15:0] delay_ms,
    input  logic [15:0] repeat_ms,
    output logic [15:0] delay_ticks,
    output logic [15:0] period_ticks
);

    logic [31:0] delay_prod_reg;
    logic [31:0] delay_prod_next;
    logic [31:0] period_prod_reg;
    logic [31:0] period_prod_next;

    assign delay_prod_next  = 32'(delay_ms) * 32'(RECIP10);
    assign period_prod_next = 32'(repeat_ms) * 32'(RECIP10);

    always_ff @(posedge clk)
    begin
        delay_prod_reg  <= delay_prod_next;
        period_prod_reg <= period_prod_next;
    end

    assign delay_ticks  = 16'(delay_prod_reg[31:DIV10_SHIFT]) + 16'd1;
    assign period_ticks = 16'(period_prod_reg[31:DIV10_SHIFT]) + 16'd1;

endmodule

// ===== design/periodic_task_timer_table_top.sv =====
// Periodic task timer table: an add passes the ST_ADD state (busy) and then the result register,
// while a reject or a nothing-ready result shows in the cycle after start. Tick and dispatch walk
// the table memory one slot per cycle while busy; a dispatch result passes the memory read
// register and then the result register. The single read/write port pair of the slot memory
// sets the walk rate. Reset clears the control registers and the occupancy and ready bits;
// the memory needs no clearing pass. Results show for one cycle on valid; the receiver cannot stall.
module periodic_task_timer_table_top
    import ptt_pkg::*;
#(
    parameter int SLOT_COUNT = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  operation,
    input  logic [15:0] task_handle,
    input  logic [15:0] delay_ms,
    input  logic [15:0] repeat_ms,
    output logic        valid,
    output logic [1:0]  kind,
    output logic [15:0] task_handle_out,
    output logic [2:0]  slot,
    output logic        last
);

    localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CNT_W  = SLOT_W + 1;

    typedef enum logic [1:0] {ST_IDLE, ST_ADD, ST_WALK} state_t;

    state_t             state_reg, state_next;
    logic [SLOT_COUNT-1:0] used_reg, used_next;
    logic [SLOT_COUNT-1:0] ready_reg, ready_next;
    logic [CNT_W-1:0]   rd_cnt_reg, rd_cnt_next;
    logic               wb_valid_reg, wb_valid_next;
    logic [SLOT_W-1:0]  wb_idx_reg, wb_idx_next;
    logic               is_disp_reg, is_disp_next;
    logic [SLOT_W-1:0]  add_idx_reg, add_idx_next;
    logic [15:0]        add_handle_reg, add_handle_next;
    logic               valid_reg, valid_next;
    logic [1:0]         kind_reg, kind_next;
    logic [15:0]        handle_out_reg, handle_out_next;
    logic [2:0]         slot_reg, slot_next;
    logic               last_reg, last_next;

    logic               any_free;
    logic [SLOT_W-1:0]  free_idx;
    logic [SLOT_COUNT-1:0] above_mask;
    logic [SLOT_W-1:0]  rd_idx;
    logic [SLOT_W+2:0]  add_slot_ext;
    logic [SLOT_W+2:0]  wb_slot_ext;
    logic [15:0]        ticks_dec;
    logic [7:0]         pend_new;

    logic               mem_rd_en;
    entry_t             mem_rd_data;
    logic               mem_wr_en;
    logic [SLOT_W-1:0]  mem_wr_addr;
    entry_t             mem_wr_data;
    logic [15:0]        delay_ticks;
    logic [15:0]        period_ticks;

    ptt_mem #(
        .DEPTH  (SLOT_COUNT),
        .ADDR_W (SLOT_W)
    ) u_mem (
        .clk     (clk),
        .rd_en   (mem_rd_en),
        .rd_addr (rd_idx),
        .rd_data (mem_rd_data),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data)
    );

    ptt_conv u_conv (
        .clk          (clk),
        .delay_ms     (delay_ms),
        .repeat_ms    (repeat_ms),
        .delay_ticks  (delay_ticks),
        .period_ticks (period_ticks)
    );

    always_comb
    begin
        any_free = 1'b0;
        free_idx = '0;
        for (int i = SLOT_COUNT - 1; i >= 0; i--)
        begin
            if (!used_reg[i])
            begin
                any_free = 1'b1;
                free_idx = SLOT_W'(i);
            end
        end
    end

    always_comb
    begin
        for (int j = 0; j < SLOT_COUNT; j++)
        begin
            above_mask[j] = CNT_W'(j) > {1'b0, wb_idx_reg};
        end
    end

    assign rd_idx       = rd_cnt_reg[SLOT_W-1:0];
    assign add_slot_ext = {3'b000, add_idx_reg};
    assign wb_slot_ext  = {3'b000, wb_idx_reg};
    assign ticks_dec    = mem_rd_data.ticks - 16'd1;

    always_comb
    begin
        state_next      = state_reg;
        used_next       = used_reg;
        ready_next      = ready_reg;
        rd_cnt_next     = rd_cnt_reg;
        wb_valid_next   = 1'b0;
        wb_idx_next     = wb_idx_reg;
        is_disp_next    = is_disp_reg;
        add_idx_next    = add_idx_reg;
        add_handle_next = add_handle_reg;
        valid_next      = 1'b0;
        kind_next       = kind_reg;
        handle_out_next = handle_out_reg;
        slot_next       = slot_reg;
        last_next       = last_reg;
        mem_rd_en       = 1'b0;
        mem_wr_en       = 1'b0;
        mem_wr_addr     = wb_idx_reg;
        mem_wr_data     = mem_rd_data;
        pend_new        = mem_rd_data.pending;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    case (operation)
                        OP_ADD:
                        begin
                            if (any_free)
                            begin
                                add_idx_next    = free_idx;
                                add_handle_next = task_handle;
                                state_next      = ST_ADD;
                            end
                            else
                            begin
                                valid_next      = 1'b1;
                                kind_next       = KIND_REJECTED;
                                handle_out_next = task_handle;
                                slot_next       = 3'd0;
                                last_next       = 1'b1;
                            end
                        end
                        OP_TICK:
                        begin
                            is_disp_next = 1'b0;
                            rd_cnt_next  = '0;
                            state_next   = ST_WALK;
                        end
                        OP_DISPATCH:
                        begin
                            if ((used_reg & ready_reg) == '0)
                            begin
                                valid_next      = 1'b1;
                                kind_next       = KIND_NONE;
                                handle_out_next = 16'd0;
                                slot_next       = 3'd0;
                                last_next       = 1'b1;
                            end
                            else
                            begin
                                is_disp_next = 1'b1;
                                rd_cnt_next  = '0;
                                state_next   = ST_WALK;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            ST_ADD:
            begin
                mem_wr_en             = 1'b1;
                mem_wr_addr           = add_idx_reg;
                mem_wr_data.handle    = add_handle_reg;
                mem_wr_data.ticks     = delay_ticks;
                mem_wr_data.period    = period_ticks;
                mem_wr_data.pending   = 8'd0;
                used_next[add_idx_reg]  = 1'b1;
                ready_next[add_idx_reg] = 1'b0;
                valid_next            = 1'b1;
                kind_next             = KIND_ADDED;
                handle_out_next       = add_handle_reg;
                slot_next             = add_slot_ext[2:0];
                last_next             = 1'b1;
                state_next            = ST_IDLE;
            end

            ST_WALK:
            begin
                // issue the read of the next slot
                if (rd_cnt_reg == CNT_W'(SLOT_COUNT))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    mem_rd_en     = used_reg[rd_idx] && (!is_disp_reg || ready_reg[rd_idx]);
                    wb_valid_next = mem_rd_en;
                    wb_idx_next   = rd_idx;
                    rd_cnt_next   = rd_cnt_reg + CNT_W'(1);
                end

                // modify and write back the slot read last cycle
                if (wb_valid_reg)
                begin
                    mem_wr_en = 1'b1;
                    if (is_disp_reg)
                    begin
                        pend_new        = mem_rd_data.pending - 8'd1;
                        valid_next      = 1'b1;
                        kind_next       = KIND_RUN;
                        handle_out_next = mem_rd_data.handle;
                        slot_next       = wb_slot_ext[2:0];
                        last_next       = (used_reg & ready_reg & above_mask) == '0;
                    end
                    else if (ticks_dec == 16'd0)
                    begin
                        if (mem_rd_data.pending != PENDING_MAX)
                        begin
                            pend_new = mem_rd_data.pending + 8'd1;
                        end
                        mem_wr_data.ticks = mem_rd_data.period;
                    end
                    else
                    begin
                        mem_wr_data.ticks = ticks_dec;
                    end
                    mem_wr_data.pending    = pend_new;
                    ready_next[wb_idx_reg] = pend_new != 8'd0;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            used_reg       <= '0;
            ready_reg      <= '0;
            rd_cnt_reg     <= '0;
            wb_valid_reg   <= 1'b0;
            wb_idx_reg     <= '0;
            is_disp_reg    <= 1'b0;
            add_idx_reg    <= '0;
            add_handle_reg <= '0;
            valid_reg      <= 1'b0;
            kind_reg       <= KIND_ADDED;
            handle_out_reg <= '0;
            slot_reg       <= '0;
            last_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            used_reg       <= used_next;
            ready_reg      <= ready_next;
            rd_cnt_reg     <= rd_cnt_next;
            wb_valid_reg   <= wb_valid_next;
            wb_idx_reg     <= wb_idx_next;
            is_disp_reg    <= is_disp_next;
            add_idx_reg    <= add_idx_next;
            add_handle_reg <= add_handle_next;
            valid_reg      <= valid_next;
            kind_reg       <= kind_next;
            handle_out_reg <= handle_out_next;
            slot_reg       <= slot_next;
            last_reg       <= last_next;
        end
    end

    assign busy            = state_reg != ST_IDLE;
    assign valid           = valid_reg;
    assign kind            = kind_reg;
    assign task_handle_out = handle_out_reg;
    assign slot            = slot_reg;
    assign last            = last_reg;

endmodule

// ===== design/ptt_checker.sv =====
// Port-level checks for the periodic task timer table, bound to the top level.
// Depends on ptt_pkg for operation and result codes.
module ptt_checker
    import ptt_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic [1:0]  operation,
    input logic        valid,
    input logic [1:0]  kind,
    input logic [2:0]  slot,
    input logic        last
);

    logic accept;
    assign accept = start && !busy;

    a_tick_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && operation == OP_TICK) |=> !valid)
        else $error("tick transaction produced a result");

    a_add_answers: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (operation == OP_ADD || operation == OP_DISPATCH)) |=> (valid || busy))
        else $error("add or dispatch transaction left no trace");

    a_only_runs_continue: assert property (@(posedge clk) disable iff (!rst_n)
        (valid && !last) |-> (kind == KIND_RUN && busy))
        else $error("non-final result outside a dispatch walk");

    a_reject_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (valid && (kind == KIND_REJECTED || kind == KIND_NONE)) |-> (last && slot == 3'd0))
        else $error("reject or nothing-ready result malformed");

endmodule

bind periodic_task_timer_table_top ptt_checker u_ptt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .operation (operation),
    .valid     (valid),
    .kind      (kind),
    .slot      (slot),
    .last      (last)
);

// ===== verif/tb_top.sv =====
// Self-checking testbench for periodic_task_timer_table_top: adds, ticks and dispatches
// driven over the start/busy handshake and checked against an in-bench slot table.
// Depends on ptt_pkg and the top level of the block.
`timescale 1ns / 100ps

module tb_top;
    import ptt_pkg::*;

    localparam int SLOTS         = 8;
    localparam int RANDOM_ITEMS  = 12;
    localparam int SAT_TICKS     = 256;
    localparam int DRAIN_CYCLES  = 2 * SLOTS + 8;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int PRINT_LIMIT   = 200;
    localparam logic [1:0] OP_IGNORED = 2'd3;

    typedef struct packed {
        logic [1:0]  op;
        logic [15:0] handle;
        logic [15:0] first_ms;
        logic [15:0] every_ms;
    } cmd_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] handle;
        logic [2:0]  slot;
        logic        last;
    } sched_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  operation = '0;
    logic [15:0] task_handle = '0;
    logic [15:0] delay_ms = '0;
    logic [15:0] repeat_ms = '0;
    logic        valid;
    logic [1:0]  kind;
    logic [15:0] task_handle_out;
    logic [2:0]  slot;
    logic        last;

    cmd_t          pending_cmds[$];
    sched_result_t sched_events[$];
    cmd_t          cur_cmd;

    logic          tbl_used[SLOTS];
    logic [15:0]   tbl_handle[SLOTS];
    logic [15:0]   tbl_countdown[SLOTS];
    logic [15:0]   tbl_period[SLOTS];
    logic [7:0]    tbl_pending[SLOTS];

    int total_cmds;
    int accepted_cnt;
    int results_seen;
    int runs_seen;
    int rejects_seen;
    int mismatch_cnt;
    int cycle_cnt;

    periodic_task_timer_table_top #(
        .SLOT_COUNT(SLOTS)
    ) dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .operation       (operation),
        .task_handle     (task_handle),
        .delay_ms        (delay_ms),
        .repeat_ms       (repeat_ms),
        .valid           (valid),
        .kind            (kind),
        .task_handle_out (task_handle_out),
        .slot            (slot),
        .last            (last)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic logic [15:0] ticks_from_ms(logic [15:0] ms);
        return (ms / 16'd10) + 16'd1;
    endfunction

    function automatic void clear_task_table();
        for (int i = 0; i < SLOTS; i++)
        begin
            tbl_used[i]      = 1'b0;
            tbl_handle[i]    = '0;
            tbl_countdown[i] = '0;
            tbl_period[i]    = '0;
            tbl_pending[i]   = '0;
        end
    endfunction

    function automatic void step_task_table(cmd_t c);
        logic found;
        int   ready;
        int   k;
        found = 1'b0;
        ready = 0;
        k = 0;
        case (c.op)
            OP_ADD:
            begin
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (!found && !tbl_used[i])
                    begin
                        found            = 1'b1;
                        tbl_used[i]      = 1'b1;
                        tbl_handle[i]    = c.handle;
                        tbl_countdown[i] = ticks_from_ms(c.first_ms);
                        tbl_period[i]    = ticks_from_ms(c.every_ms);
                        tbl_pending[i]   = '0;
                        sched_events.push_back({KIND_ADDED, c.handle, 3'(i), 1'b1});
                    end
                end
                if (!found)
                    sched_events.push_back({KIND_REJECTED, c.handle, 3'd0, 1'b1});
            end
            OP_TICK:
            begin
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (tbl_used[i])
                    begin
                        tbl_countdown[i] = tbl_countdown[i] - 16'd1;
                        if (tbl_countdown[i] == 16'd0)
                        begin
                            if (tbl_pending[i] != PENDING_MAX)
                                tbl_pending[i] = tbl_pending[i] + 8'd1;
                            tbl_countdown[i] = tbl_period[i];
                        end
                    end
                end
            end
            OP_DISPATCH:
            begin
                for (int i = 0; i < SLOTS; i++)
                    if (tbl_used[i] && tbl_pending[i] != 8'd0)
                        ready++;
                if (ready == 0)
                    sched_events.push_back({KIND_NONE, 16'd0, 3'd0, 1'b1});
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (tbl_used[i] && tbl_pending[i] != 8'd0)
                    begin
                        k++;
                        sched_events.push_back({KIND_RUN, tbl_handle[i], 3'(i),
                                                k == ready});
                        tbl_pending[i] = tbl_pending[i] - 8'd1;
                    end
                end
            end
            default:
            begin
            end
        endcase
    endfunction

    task automatic push_cmd(logic [1:0] op, logic [15:0] h, logic [15:0] d, logic [15:0] r);
        pending_cmds.push_back({op, h, d, r});
    endtask

    task automatic push_noisy(logic [1:0] op);
        push_cmd(op, 16'($urandom), 16'($urandom), 16'($urandom));
    endtask

    task automatic flag_mismatch(string what, logic [15:0] got, logic [15:0] want);
        mismatch_cnt++;
        if (mismatch_cnt <= PRINT_LIMIT)
            $display("%0t: mismatch on %s: got %h, want %h", $realtime, what, got, want);
    endtask

    // hold start and the fields until busy is low, then advance to the next transaction
    always @(posedge clk)
    begin : driver
        cmd_t nxt;
        int   idle_pct;
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else
        begin
            if (start && !busy)
            begin
                step_task_table(cur_cmd);
                accepted_cnt++;
            end
            if (!start || !busy)
            begin
                if (accepted_cnt * 3 < total_cmds)
                    idle_pct = 23;
                else if (accepted_cnt * 3 < total_cmds * 2)
                    idle_pct = 64;
                else
                    idle_pct = 0;
                if (pending_cmds.size() != 0 && $urandom_range(99) >= idle_pct)
                begin
                    nxt = pending_cmds.pop_front();
                    cur_cmd = nxt;
                    start       <= 1'b1;
                    operation   <= nxt.op;
                    task_handle <= nxt.handle;
                    delay_ms    <= nxt.first_ms;
                    repeat_ms   <= nxt.every_ms;
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin : monitor
        sched_result_t want;
        if (rst_n && valid)
        begin
            if (sched_events.size() == 0)
            begin
                flag_mismatch("unexpected result handle", task_handle_out, 16'd0);
            end
            else
            begin
                want = sched_events.pop_front();
                results_seen++;
                if (kind == KIND_RUN)
                    runs_seen++;
                if (kind == KIND_REJECTED)
                    rejects_seen++;
                if (kind !== want.kind)
                    flag_mismatch("kind", 16'(kind), 16'(want.kind));
                if (task_handle_out !== want.handle)
                    flag_mismatch("task_handle_out", task_handle_out, want.handle);
                if (slot !== want.slot)
                    flag_mismatch("slot", 16'(slot), 16'(want.slot));
                if (last !== want.last)
                    flag_mismatch("last", 16'(last), 16'(want.last));
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("run stopped by watchdog after %0d cycles", cycle_cnt);
            $display("tb_top NOT OK");
            $finish;
        end
    end

    initial
    begin : stimulus
        int counted;
        int pick;
        int n;
        clear_task_table();
        counted = 0;

        // empty table, ignored opcode, extreme handles and times, full table
        push_noisy(OP_DISPATCH);
        push_noisy(OP_TICK);
        push_noisy(OP_IGNORED);
        push_cmd(OP_ADD, 16'h0000, 16'h0000, 16'h0000);
        push_cmd(OP_ADD, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        push_noisy(OP_DISPATCH);
        push_noisy(OP_TICK);
        push_noisy(OP_DISPATCH);
        push_cmd(OP_ADD, 16'($urandom), 16'd9, 16'd10);
        push_cmd(OP_ADD, 16'($urandom), 16'd15, 16'd25);
        repeat (3) push_noisy(OP_TICK);
        push_noisy(OP_DISPATCH);
        push_noisy(OP_IGNORED);
        for (int i = 0; i < 4; i++)
            push_cmd(OP_ADD, 16'($urandom), 16'($urandom_range(99)), 16'($urandom_range(299)));
        push_cmd(OP_ADD, 16'hA5A5, 16'h5A5A, 16'hFFFF);
        push_noisy(OP_TICK);
        push_noisy(OP_DISPATCH);

        // drive the pending count of the fastest slot into saturation
        repeat (SAT_TICKS) push_noisy(OP_TICK);
        repeat (3) push_noisy(OP_DISPATCH);

        while (counted < RANDOM_ITEMS)
        begin
            pick = $urandom_range(99);
            if (pick < 40)
            begin
                push_noisy(OP_TICK);
                counted++;
            end
            else if (pick < 65)
            begin
                push_noisy(OP_DISPATCH);
                counted++;
            end
            else if (pick < 75)
            begin
                n = $urandom_range(10, 2);
                repeat (n) push_noisy(OP_TICK);
                repeat ($urandom_range(3, 1)) push_noisy(OP_DISPATCH);
                counted += n + 1;
            end
            else if (pick < 88)
            begin
                push_noisy(OP_ADD);
                counted++;
            end
            else if (pick < 95)
            begin
                n = $urandom_range(4, 2);
                repeat (n) push_noisy(OP_DISPATCH);
                counted += n;
            end
            else
            begin
                push_noisy(OP_IGNORED);
            end
        end
        total_cmds = pending_cmds.size();

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_cmds.size() != 0 || start || busy || sched_events.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sched_events.size() != 0)
            flag_mismatch("results never produced", 16'(sched_events.size()), 16'd0);

        $display("covered %0d transactions, %0d results checked (%0d runs, %0d rejected adds)",
                 accepted_cnt, results_seen, runs_seen, rejects_seen);
        $display("mismatches: %0d, cycles: %0d", mismatch_cnt, cycle_cnt);
        if (mismatch_cnt == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule
